// ===== rtl/slf_pkg.sv =====
`timescale 1ns / 1ps

package slf_pkg;

    typedef struct packed {
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [23:0] offset_z;
    } query_t;

    typedef struct packed {
        logic [31:0] intensity;
        logic        saturated;
    } result_t;

    typedef enum logic [2:0] {
        REG_AXIS_X     = 3'd0,
        REG_AXIS_Y     = 3'd1,
        REG_AXIS_Z     = 3'd2,
        REG_COS_INNER  = 3'd3,
        REG_COS_OUTER  = 3'd4,
        REG_EXPOSURE   = 3'd5,
        REG_DECAY_MODE = 3'd6
    } cfg_reg_t;

    localparam logic [16:0] SHAPE_ONE = 17'h10000;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [16:0] POW2_FRAC [16] = '{
        17'd65536,  17'd68438,  17'd71468,  17'd74632,
        17'd77936,  17'd81386,  17'd84990,  17'd88752,
        17'd92682,  17'd96785,  17'd101070, 17'd105545,
        17'd110218, 17'd115098, 17'd120194, 17'd125515
    };

    // Taylor series of the raised cosine 0.5 - 0.5cos(pi*k/2^bits) in Q0.16.
    function automatic logic [31:0] raised_half(input int unsigned k,
                                                input int unsigned bits);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] c;
        logic [63:0] term;
        u = (64'(k) * PI_Q30) >> bits;
        u2 = (u * u) >> 30;
        c = Q30_ONE;
        term = ((u2 * c) >> 30) / 64'd132;
        c = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((u2 * c) >> 30) / 64'd90;
        c = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((u2 * c) >> 30) / 64'd56;
        c = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((u2 * c) >> 30) / 64'd30;
        c = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((u2 * c) >> 30) / 64'd12;
        c = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        term = ((u2 * c) >> 30) / 64'd2;
        c = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
        return 32'(((Q30_ONE - c) + (64'd1 << 14)) >> 15);
    endfunction

    function automatic logic [16:0] shape_entry(input int unsigned k,
                                                input int unsigned bits);
        int unsigned n;
        logic [31:0] rh;
        n = 32'd1 << bits;
        if (2 * k <= n) begin
            rh = raised_half(k, bits);
            return rh[16:0];
        end
        rh = 32'd65536 - raised_half(n - k, bits);
        return rh[16:0];
    endfunction

endpackage

// ===== rtl/slf_div.sv =====
`timescale 1ns / 1ps

module slf_div #(
    parameter int DEN_W  = 32,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [Q_W-1:0]    num_lo,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg [Q_W];
    logic [DEN_W-1:0]  rem_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [Q_W-1:0]    lo_reg    [Q_W];
    logic [Q_W-1:0]    quot_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic              v_cur;
        logic [DEN_W-1:0]  rem_cur;
        logic [DEN_W-1:0]  den_cur;
        logic [Q_W-1:0]    lo_cur;
        logic [Q_W-1:0]    quot_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [Q_W-1:0]    quot_next;
        logic [Q_W-1:0]    lo_next;

        if (i == 0)
        begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = rem_init;
            assign den_cur  = den;
            assign lo_cur   = num_lo;
            assign quot_cur = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign v_cur    = valid_reg[i-1];
            assign rem_cur  = rem_reg[i-1];
            assign den_cur  = den_reg[i-1];
            assign lo_cur   = lo_reg[i-1];
            assign quot_cur = quot_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        always_comb
        begin
            trial = {rem_cur, lo_cur[Q_W-1]};
            ge = (trial >= {1'b0, den_cur});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_cur}) : trial[DEN_W-1:0];
            quot_next = {quot_cur[Q_W-2:0], ge};
            lo_next = {lo_cur[Q_W-2:0], 1'b0};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_cur;
                lo_reg[i]   <= lo_next;
                quot_reg[i] <= quot_next;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quot      = quot_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

// ===== rtl/slf_sqrt.sv =====
`timescale 1ns / 1ps

module slf_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [31:0]       root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STEPS = 32;

    logic              valid_reg [STEPS];
    logic [32:0]       rem_reg   [STEPS];
    logic [31:0]       root_reg  [STEPS];
    logic [63:0]       rad_reg   [STEPS];
    logic [SIDE_W-1:0] side_reg  [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        logic              v_cur;
        logic [32:0]       rem_cur;
        logic [31:0]       root_cur;
        logic [63:0]       rad_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [34:0]       trial;
        logic [34:0]       test;
        logic              ge;
        logic [32:0]       rem_next;
        logic [31:0]       root_next;
        logic [63:0]       rad_next;

        if (i == 0)
        begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign rad_cur  = radicand;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign v_cur    = valid_reg[i-1];
            assign rem_cur  = rem_reg[i-1];
            assign root_cur = root_reg[i-1];
            assign rad_cur  = rad_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        always_comb
        begin
            trial = {rem_cur, rad_cur[63:62]};
            test = {1'b0, root_cur, 2'b01};
            ge = (trial >= test);
            rem_next = ge ? 33'(trial - test) : trial[32:0];
            root_next = {root_cur[30:0], ge};
            rad_next = {rad_cur[61:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= rad_next;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

// ===== rtl/slf_shape.sv =====
`timescale 1ns / 1ps

module slf_shape #(
    parameter int TABLE_BITS = 8,
    parameter int SIDE_W     = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [16:0]       t,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [16:0]       s,
    output logic [SIDE_W-1:0] side_out
);

    import slf_pkg::*;

    localparam int FR_W   = 16 - TABLE_BITS;
    localparam int N      = 1 << TABLE_BITS;
    localparam int PROD_W = 18 + FR_W + 1;

    logic [16:0] shape_rom [N+1];

    for (genvar k = 0; k <= N; k++)
    begin : g_rom
        assign shape_rom[k] = shape_entry(k, TABLE_BITS);
    end

    logic [TABLE_BITS:0]   idx;
    logic [TABLE_BITS:0]   a_addr;
    logic [TABLE_BITS:0]   b_addr;
    logic [16:0]           a_next;
    logic [16:0]           b_next;
    logic                  va_reg;
    logic [16:0]           a_reg;
    logic [16:0]           b_reg;
    logic [FR_W-1:0]       fr_reg;
    logic [SIDE_W-1:0]     side_a_reg;

    logic signed [17:0]    diff;
    logic signed [PROD_W-1:0] prod_next;
    logic                  vb_reg;
    logic [16:0]           a_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SIDE_W-1:0]     side_b_reg;

    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] step;
    logic signed [18:0]    sum;
    logic [16:0]           s_next;
    logic                  vc_reg;
    logic [16:0]           s_reg;
    logic [SIDE_W-1:0]     side_c_reg;

    always_comb
    begin
        idx = t[16:FR_W];
        a_addr = {1'b0, idx[TABLE_BITS-1:0]};
        b_addr = a_addr + 1'b1;
        a_next = idx[TABLE_BITS] ? shape_rom[N] : shape_rom[a_addr];
        b_next = idx[TABLE_BITS] ? shape_rom[N] : shape_rom[b_addr];
    end

    always_comb
    begin
        diff = $signed({1'b0, b_reg}) - $signed({1'b0, a_reg});
        prod_next = diff * $signed({1'b0, fr_reg});
    end

    always_comb
    begin
        adj = prod_reg[PROD_W-1] ? prod_reg + PROD_W'((1 << FR_W) - 1) : prod_reg;
        step = adj >>> FR_W;
        sum = $signed({2'b00, a_b_reg}) + step[18:0];
        s_next = sum[18] ? 17'd0 : sum[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            fr_reg     <= t[FR_W-1:0];
            side_a_reg <= side_in;
            a_b_reg    <= a_reg;
            prod_reg   <= prod_next;
            side_b_reg <= side_a_reg;
            s_reg      <= s_next;
            side_c_reg <= side_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign s         = s_reg;
    assign side_out  = side_c_reg;

endmodule

// ===== rtl/spot_light_falloff.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// query     in         query_valid / query_stall  slf_pkg::query_t
// result    out        result_valid / result_stall slf_pkg::result_t
// config    in         cfg_we                      cfg_index, cfg_data
//
// One item enters per clock unless a stalled result holds the whole pipeline.
// The pipeline is built around the 32-step square root, the two 17-step dividers for the
// cone factor and penumbra position, and the 32-step divider for the squared distance.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled result freezes the whole pipeline, so query_stall follows it at once.

module spot_light_falloff #(
    parameter int COS_TABLE_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             query_valid,
    output logic             query_stall,
    input  slf_pkg::query_t  query,
    output logic             result_valid,
    input  logic             result_stall,
    output slf_pkg::result_t result
);

    import slf_pkg::*;

    logic signed [15:0] axis_x_reg;
    logic signed [15:0] axis_y_reg;
    logic signed [15:0] axis_z_reg;
    logic signed [15:0] cos_inner_reg;
    logic signed [15:0] cos_outer_reg;
    logic signed [7:0]  exposure_reg;
    logic               decay_mode_reg;

    logic adv;
    logic const_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg     <= 16'sd0;
            axis_y_reg     <= 16'sd0;
            axis_z_reg     <= -16'sd32768;
            cos_inner_reg  <= 16'sd32767;
            cos_outer_reg  <= 16'sd32767;
            exposure_reg   <= 8'sd0;
            decay_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AXIS_X:     axis_x_reg     <= cfg_data;
                REG_AXIS_Y:     axis_y_reg     <= cfg_data;
                REG_AXIS_Z:     axis_z_reg     <= cfg_data;
                REG_COS_INNER:  cos_inner_reg  <= cfg_data;
                REG_COS_OUTER:  cos_outer_reg  <= cfg_data;
                REG_EXPOSURE:   exposure_reg   <= cfg_data[7:0];
                REG_DECAY_MODE: decay_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign const_mode = (exposure_reg == 8'sd0) && !decay_mode_reg;

    // Squares and axis products.
    logic signed [47:0] sqx_full;
    logic signed [47:0] sqy_full;
    logic signed [47:0] sqz_full;
    logic signed [39:0] px_next;
    logic signed [39:0] py_next;
    logic signed [39:0] pz_next;
    logic               v1_reg;
    logic [46:0]        sqx_reg;
    logic [46:0]        sqy_reg;
    logic [46:0]        sqz_reg;
    logic signed [39:0] px_reg;
    logic signed [39:0] py_reg;
    logic signed [39:0] pz_reg;

    always_comb
    begin
        sqx_full = query.offset_x * query.offset_x;
        sqy_full = query.offset_y * query.offset_y;
        sqz_full = query.offset_z * query.offset_z;
        px_next = query.offset_x * axis_x_reg;
        py_next = query.offset_y * axis_y_reg;
        pz_next = query.offset_z * axis_z_reg;
    end

    // Sums.
    logic               v2_reg;
    logic [47:0]        sumsq_reg;
    logic signed [41:0] dot_reg;
    logic signed [41:0] dot_abs;
    logic [88:0]        sq_side_in;

    always_comb
    begin
        dot_abs = dot_reg[41] ? -dot_reg : dot_reg;
        sq_side_in = {sumsq_reg, (dot_reg > 42'sd0), dot_abs[39:0]};
    end

    logic        sq_valid;
    logic [31:0] sq_root;
    logic [88:0] sq_side;

    slf_sqrt #(
        .SIDE_W(89)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (v2_reg),
        .radicand ({sumsq_reg, 16'd0}),
        .side_in  (sq_side_in),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_out (sq_side)
    );

    logic        fd_valid;
    logic [16:0] fd_quot;
    logic [48:0] fd_side;

    slf_div #(
        .DEN_W (32),
        .Q_W   (17),
        .SIDE_W(49)
    ) u_div_cone (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (sq_valid),
        .rem_init ({1'b0, sq_side[39:9]}),
        .num_lo   ({sq_side[8:0], 8'd0}),
        .den      (sq_root),
        .side_in  (sq_side[88:40]),
        .out_valid(fd_valid),
        .quot     (fd_quot),
        .side_out (fd_side)
    );

    // Clamp into the penumbra.
    logic signed [17:0] f_val;
    logic signed [17:0] ci18;
    logic signed [17:0] co18;
    logic signed [17:0] c_val;
    logic signed [17:0] num_full;
    logic signed [17:0] den_full;
    logic               pos_next;
    logic               cl_valid_reg;
    logic [15:0]        num_reg;
    logic [15:0]        den_reg;
    logic               pos_reg;
    logic               inv_one_reg;
    logic               hard_reg;
    logic               hard_s_reg;
    logic [47:0]        sumsq_c_reg;

    always_comb
    begin
        f_val = fd_side[0] ? -$signed({1'b0, fd_quot}) : $signed({1'b0, fd_quot});
        ci18 = 18'(cos_inner_reg);
        co18 = 18'(cos_outer_reg);
        c_val = (f_val > ci18) ? ci18 : ((f_val < co18) ? co18 : f_val);
        num_full = c_val - co18;
        den_full = ci18 - co18;
        pos_next = (den_full > 18'sd0);
    end

    logic        td_valid;
    logic [16:0] td_quot;
    logic [51:0] td_side;

    slf_div #(
        .DEN_W (16),
        .Q_W   (17),
        .SIDE_W(52)
    ) u_div_pen (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (cl_valid_reg),
        .rem_init ({1'b0, num_reg[15:1]}),
        .num_lo   ({num_reg[0], 16'd0}),
        .den      (den_reg),
        .side_in  ({sumsq_c_reg, hard_reg, hard_s_reg, pos_reg, inv_one_reg}),
        .out_valid(td_valid),
        .quot     (td_quot),
        .side_out (td_side)
    );

    logic [16:0] t_val;

    always_comb
    begin
        if (td_side[1])
        begin
            t_val = td_quot;
        end
        else
        begin
            t_val = td_side[0] ? SHAPE_ONE : 17'd0;
        end
    end

    logic        sh_valid;
    logic [16:0] sh_s;
    logic [49:0] sh_side;

    slf_shape #(
        .TABLE_BITS(COS_TABLE_BITS),
        .SIDE_W    (50)
    ) u_shape (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (td_valid),
        .t        (t_val),
        .side_in  (td_side[51:2]),
        .out_valid(sh_valid),
        .s        (sh_s),
        .side_out (sh_side)
    );

    // Exposure scale and decay numerator.
    logic [16:0] s_val;
    logic [7:0]  exp_u;
    logic        e1_valid_reg;
    logic [33:0] prod_reg;
    logic [16:0] s_e1_reg;
    logic [47:0] sumsq_e1_reg;
    logic [48:0] n_next;
    logic        e2_valid_reg;
    logic [48:0] n_reg;
    logic        over_reg;
    logic        zero_reg;
    logic [16:0] s_e2_reg;
    logic [47:0] sumsq_e2_reg;

    always_comb
    begin
        if (sh_side[1])
        begin
            s_val = sh_side[0] ? SHAPE_ONE : 17'd0;
        end
        else
        begin
            s_val = sh_s;
        end
        exp_u = exposure_reg ^ 8'h80;
        n_next = 49'(prod_reg) << exp_u[7:4];
    end

    logic        dd_valid;
    logic [31:0] dd_quot;
    logic [18:0] dd_side;

    slf_div #(
        .DEN_W (48),
        .Q_W   (32),
        .SIDE_W(19)
    ) u_div_decay (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (e2_valid_reg),
        .rem_init (over_reg ? 48'd0 : {31'd0, n_reg[48:32]}),
        .num_lo   (n_reg[31:0]),
        .den      (zero_reg ? 48'd1 : sumsq_e2_reg),
        .side_in  ({s_e2_reg, zero_reg, over_reg}),
        .out_valid(dd_valid),
        .quot     (dd_quot),
        .side_out (dd_side)
    );

    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        if (dd_side[1] || (!const_mode && dd_side[0]))
        begin
            result_next.intensity = '1;
            result_next.saturated = 1'b1;
        end
        else if (const_mode)
        begin
            result_next.intensity = {15'd0, dd_side[18:2]};
            result_next.saturated = 1'b0;
        end
        else
        begin
            result_next.intensity = dd_quot;
            result_next.saturated = 1'b0;
        end
    end

    assign adv = !(result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            cl_valid_reg     <= 1'b0;
            e1_valid_reg     <= 1'b0;
            e2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg           <= query_valid;
            v2_reg           <= v1_reg;
            cl_valid_reg     <= fd_valid;
            e1_valid_reg     <= sh_valid;
            e2_valid_reg     <= e1_valid_reg;
            result_valid_reg <= dd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg      <= sqx_full[46:0];
            sqy_reg      <= sqy_full[46:0];
            sqz_reg      <= sqz_full[46:0];
            px_reg       <= px_next;
            py_reg       <= py_next;
            pz_reg       <= pz_next;
            sumsq_reg    <= 48'(sqx_reg) + 48'(sqy_reg) + 48'(sqz_reg);
            dot_reg      <= 42'(px_reg) + 42'(py_reg) + 42'(pz_reg);
            num_reg      <= pos_next ? num_full[15:0] : 16'd0;
            den_reg      <= pos_next ? den_full[15:0] : 16'd1;
            pos_reg      <= pos_next;
            inv_one_reg  <= (f_val > ci18);
            hard_reg     <= (ci18 == co18);
            hard_s_reg   <= (f_val >= ci18);
            sumsq_c_reg  <= fd_side[48:1];
            prod_reg     <= s_val * POW2_FRAC[exp_u[3:0]];
            s_e1_reg     <= s_val;
            sumsq_e1_reg <= sh_side[49:2];
            n_reg        <= n_next;
            over_reg     <= (48'(n_next[48:32]) >= sumsq_e1_reg);
            zero_reg     <= (sumsq_e1_reg == 48'd0);
            s_e2_reg     <= s_e1_reg;
            sumsq_e2_reg <= sumsq_e1_reg;
            result_reg   <= result_next;
        end
    end

    assign query_stall  = !adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // The input side is held exactly while a waiting result is stalled.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall == (result_valid && result_stall))
        else $error("query_stall does not follow a stalled result");

    // A saturated result always carries the full-scale code.
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |-> result.intensity == 32'hFFFF_FFFF)
        else $error("saturated result without full-scale intensity");

    // Without exposure or decay the shaped value never exceeds one.
    a_const_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && const_mode && !result.saturated
            |-> result.intensity <= 32'h0001_0000)
        else $error("unscaled intensity above one");

    // A stalled result stays valid and unchanged.
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_reg))
        else $error("result changed while stalled");
`endif

endmodule

// ===== test/tb_spot_light_falloff.sv =====
`timescale 1ns / 1ps

module tb_spot_light_falloff;
    import slf_pkg::*;

    localparam int TBL_BITS = 8;
    localparam int TBL_N = 1 << TBL_BITS;
    localparam int LATENCY = 107;

    class falloff_scoreboard;
        logic signed [15:0] axis [3];
        logic signed [15:0] cos_in;
        logic signed [15:0] cos_out;
        logic signed [7:0]  expo;
        logic               decay;
        bit [31:0]          ramp [TBL_N + 1];
        bit [31:0]          pow2 [16];
        result_t            pending_results [$];
        int                 errors;

        function new();
            pow2 = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                     92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515};
            for (int k = 0; k <= TBL_N; k++)
                ramp[k] = (2 * k <= TBL_N) ? half_ramp(k) : 32'd65536 - half_ramp(TBL_N - k);
            axis = '{16'sd0, 16'sd0, -16'sd32768};
            cos_in = 16'sd32767;
            cos_out = 16'sd32767;
            expo = 0;
            decay = 0;
            errors = 0;
        endfunction

        function bit [31:0] half_ramp(int k);
            bit [63:0] one;
            bit [63:0] u;
            bit [63:0] u2;
            bit [63:0] c;
            bit [63:0] term;
            bit [63:0] divs [6];
            one = 64'd1 << 30;
            divs = '{132, 90, 56, 30, 12, 2};
            u = (64'(k) * 64'd3373259426) >> TBL_BITS;
            u2 = (u * u) >> 30;
            c = one;
            for (int i = 0; i < 6; i++)
            begin
                term = ((u2 * c) >> 30) / divs[i];
                c = (term >= one) ? 64'd0 : one - term;
            end
            return 32'(((one - c) + (64'd1 << 14)) >> 15);
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint shaped(longint t);
            longint idx;
            longint fr;
            longint a;
            longint b;
            longint s;
            idx = t >>> (16 - TBL_BITS);
            fr = t & ((1 << (16 - TBL_BITS)) - 1);
            if (idx >= TBL_N)
                return ramp[TBL_N];
            a = ramp[idx];
            b = ramp[idx + 1];
            s = a + ((b - a) * fr) / (longint'(1) << (16 - TBL_BITS));
            return (s < 0) ? 0 : s;
        endfunction

        function result_t falloff(query_t q);
            result_t res;
            longint ox;
            longint oy;
            longint oz;
            longint ci;
            longint co;
            longint e;
            longint dot;
            longint f;
            longint c;
            longint num;
            longint den;
            longint t;
            longint s;
            bit [63:0] sq;
            bit [63:0] len;
            bit [63:0] mag;
            bit [63:0] n;
            bit [63:0] r;
            int eu;
            ox = q.offset_x;
            oy = q.offset_y;
            oz = q.offset_z;
            ci = cos_in;
            co = cos_out;
            e = expo;
            sq = ox * ox + oy * oy + oz * oz;
            if (sq == 0)
            begin
                res.intensity = 32'hFFFFFFFF;
                res.saturated = 1'b1;
                return res;
            end
            len = int_sqrt(sq << 16);
            dot = ox * longint'(axis[0]) + oy * longint'(axis[1]) + oz * longint'(axis[2]);
            mag = (dot > 0) ? dot : -dot;
            f = longint'((mag << 8) / len);
            if (dot > 0)
                f = -f;
            if (ci == co)
                s = (f >= ci) ? 65536 : 0;
            else
            begin
                c = (f > ci) ? ci : ((f < co) ? co : f);
                num = c - co;
                den = ci - co;
                if (den > 0)
                    t = (num * 65536) / den;
                else
                    t = (num == den) ? 65536 : 0;
                s = shaped(t);
            end
            res.saturated = 1'b0;
            if (e == 0 && !decay)
                res.intensity = 32'(s);
            else
            begin
                eu = int'(e) + 128;
                n = (64'(s) * 64'(pow2[eu & 15])) << (eu >> 4);
                r = n / sq;
                if (r > 64'hFFFFFFFF)
                begin
                    res.intensity = 32'hFFFFFFFF;
                    res.saturated = 1'b1;
                end
                else
                    res.intensity = r[31:0];
            end
            return res;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch in %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        function void note_query(query_t q);
            pending_results.push_back(falloff(q));
        endfunction

        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected item", got.intensity, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.intensity !== want.intensity)
                report("intensity", got.intensity, want.intensity);
            if (got.saturated !== want.saturated)
                report("saturated", got.saturated, want.saturated);
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [15:0]      cfg_data;
    logic             query_valid;
    logic             query_stall;
    query_t           query;
    logic             result_valid;
    logic             result_stall;
    result_t          result;

    falloff_scoreboard sb;
    bit               idling;
    int               stall_left;

    spot_light_falloff #(.COS_TABLE_BITS(TBL_BITS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .query_valid(query_valid),
        .query_stall(query_stall),
        .query(query),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (query_valid && !query_stall)
                sb.note_query(query);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    initial
    begin
        result_stall <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (idling && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 4);
            result_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    task write_reg(cfg_reg_t idx, logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_AXIS_X: sb.axis[0] = data;
            REG_AXIS_Y: sb.axis[1] = data;
            REG_AXIS_Z: sb.axis[2] = data;
            REG_COS_INNER: sb.cos_in = data;
            REG_COS_OUTER: sb.cos_out = data;
            REG_EXPOSURE: sb.expo = data[7:0];
            default: sb.decay = data[0];
        endcase
    endtask

    task set_light(int ax, int ay, int az, int ci, int co, int e, int d);
        write_reg(REG_AXIS_X, 16'(ax));
        write_reg(REG_AXIS_Y, 16'(ay));
        write_reg(REG_AXIS_Z, 16'(az));
        write_reg(REG_COS_INNER, 16'(ci));
        write_reg(REG_COS_OUTER, 16'(co));
        write_reg(REG_EXPOSURE, 16'(e));
        write_reg(REG_DECAY_MODE, 16'(d));
    endtask

    task send(int x, int y, int z);
        int gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            query_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        query_valid <= 1'b1;
        query.offset_x <= 24'(x);
        query.offset_y <= 24'(y);
        query.offset_z <= 24'(z);
        @(posedge clk);
        while (query_stall)
            @(posedge clk);
    endtask

    task drain();
        @(negedge clk);
        query_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task send_random(int count);
        int pick;
        int m;
        int k;
        int v [3];
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                m = $urandom_range(1, 255);
                k = (pick == 0) ? 0 : ((pick == 1) ? 64 : 4096);
                for (int j = 0; j < 3; j++)
                    v[j] = -int'(sb.axis[j]) * m + int'($urandom_range(0, 2 * k)) - k;
            end
            else if (pick < 7)
                for (int j = 0; j < 3; j++)
                    v[j] = $urandom;
            else if (pick < 9)
                for (int j = 0; j < 3; j++)
                    v[j] = int'($urandom_range(0, 4096)) - 2048;
            else
                for (int j = 0; j < 3; j++)
                    v[j] = int'($urandom_range(0, 4)) - 2;
            send(v[0], v[1], v[2]);
        end
    endtask

    initial
    begin
        sb = new();
        idling = 1;
        rst_n = 0;
        cfg_we <= 1'b0;
        cfg_index <= REG_AXIS_X;
        cfg_data <= '0;
        query_valid <= 1'b0;
        query <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(0, 0, 0);
        send(8388607, 8388607, 8388607);
        send(-8388608, -8388608, -8388608);
        send(0, 0, 1);
        send(0, 0, -1);
        send(0, 0, 8388607);
        send(0, 0, -8388608);
        send(1, 0, 0);
        send(0, -8388608, 0);
        send(4096, 0, 4096);
        send(100, 100, 4096);
        drain();
        set_light(0, 0, -32768, 30000, 16000, 0, 0);
        send(0, 0, 4096);
        send(2048, 0, 4096);
        send(4096, 0, 4096);
        send(4096, 0, 2048);
        send(0, 4096, 0);
        drain();
        set_light(23170, 0, -23170, 31000, 25000, 16, 1);
        send(0, 0, 0);
        send(-1, 0, 1);
        send(-8388608, 0, 8388607);
        send_random(140);
        drain();
        set_light($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                  -32768, 32767, -128, 0);
        send(0, 0, 4096);
        send(-4096, 0, 0);
        send_random(140);
        drain();
        set_light(32767, -32768, 32767, 32767, -32768, 127, 1);
        send(-1, 1, -1);
        send(-8388608, 8388607, -8388608);
        send_random(140);
        drain();
        set_light(0, 0, -32768, 30000, 16000, 0, 0);
        send_random(140);
        drain();
        set_light(0, 0, -32768, 20000, 30000, 0, 0);
        send_random(60);
        drain();
        set_light($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255),
                  $urandom_range(0, 1));
        send_random(100);
        drain();
        k_phase();
    end

    task k_phase();
        int c;
        c = $urandom_range(0, 65535);
        set_light(0, -32768, 0, c, c, 0, 1);
        idling = 0;
        send_random(140);
        drain();
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    endtask

endmodule

// ===== filelist.f =====
rtl/slf_pkg.sv
rtl/slf_div.sv
rtl/slf_sqrt.sv
rtl/slf_shape.sv
rtl/spot_light_falloff.sv
test/tb_spot_light_falloff.sv
